// ===== sv/chacha_pkg.sv =====
// Shared types and constants for the ChaCha keystream XOR core.
package chacha_pkg;

    localparam logic [31:0] C_SIGMA0 = 32'h61707865;
    localparam logic [31:0] C_TAU1   = 32'h3120646e;
    localparam logic [31:0] C_SIGMA1 = 32'h3320646e;
    localparam logic [31:0] C_TAU2   = 32'h79622d36;
    localparam logic [31:0] C_SIGMA2 = 32'h79622d32;
    localparam logic [31:0] C_SIGMA3 = 32'h6b206574;

    localparam logic [2:0] REG_KEY0   = 3'd0;
    localparam logic [2:0] REG_KEY1   = 3'd1;
    localparam logic [2:0] REG_KEY2   = 3'd2;
    localparam logic [2:0] REG_KEY3   = 3'd3;
    localparam logic [2:0] REG_KEYLEN = 3'd4;
    localparam logic [2:0] REG_NONCE  = 3'd5;
    localparam logic [2:0] REG_ROUNDS = 3'd6;

    // Queued item between front and back.
    typedef struct packed {
        logic [7:0] data;
        logic       restart;
        logic       last;
    } t_item;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_result;

endpackage

// ===== sv/chacha_front.sv =====
// Input stage and two-entry item queue.
module chacha_front
    import chacha_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_item       i_item,
    output logic        o_q_valid,
    input  logic        i_q_ready,
    output t_item       o_q_item
);

    t_item      r_mem [2];
    logic       r_wptr, r_rptr;
    logic [1:0] r_count;
    logic       w_push, w_pop;

    assign o_in_ready = (r_count != 2'd2);
    assign o_q_valid  = (r_count != 2'd0);
    assign o_q_item   = r_mem[r_rptr];
    assign w_push     = i_in_valid && o_in_ready;
    assign w_pop      = o_q_valid && i_q_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_item;
        end
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (w_push) r_wptr <= ~r_wptr;
            if (w_pop) r_rptr <= ~r_rptr;
            r_count <= r_count + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'd2) else $error("queue count overflow");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd2) |-> !w_push) else $error("push into full queue");
    a_pop_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && !w_push) |=> (r_count == $past(r_count) - 2'd1))
        else $error("pop did not drain");

endmodule

// ===== sv/chacha_back.sv =====
// Block generator, keystream buffer and output register.
module chacha_back
    import chacha_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    input  logic        i_q_valid,
    output logic        o_q_ready,
    input  t_item       i_q_item,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_result     o_out
);

    typedef enum logic [1:0] {S_IDLE, S_ROUND, S_ADD} t_state;

    t_state      r_state;
    logic [63:0] r_key0, r_key1, r_key2, r_key3, r_nonce, r_ctr;
    logic        r_long;
    logic [3:0]  r_drounds, r_dr_cnt;
    logic [2:0]  r_qr;
    logic [3:0]  r_add_idx;
    logic [6:0]  r_pos;
    logic        r_rst_done;
    logic [31:0] r_w [16];
    logic [31:0] r_ks [16];
    logic        r_out_valid;
    t_result     r_out;

    logic [31:0] w_init [16];
    logic [3:0]  w_a, w_b, w_c, w_d;
    logic [31:0] w_a1, w_d1, w_c1, w_b1, w_a2, w_d2, w_c2, w_b2;
    logic        w_need, w_take, w_key_wr, w_out_free, w_restart;
    logic [63:0] w_hi0, w_hi1, w_ctr_eff;
    logic [5:0]  w_idx;
    logic [31:0] w_word;
    logic [7:0]  w_ksb;

    assign w_key_wr  = i_cfg_we && (i_cfg_idx <= REG_KEYLEN);
    assign w_hi0     = r_long ? r_key2 : r_key0;
    assign w_hi1     = r_long ? r_key3 : r_key1;
    // Restart of the head item is served once, by the block it triggers.
    assign w_restart = i_q_item.restart && !r_rst_done;
    assign w_ctr_eff = w_restart ? 64'd0 : r_ctr;

    always_comb begin
        w_init[0]  = C_SIGMA0;
        w_init[1]  = r_long ? C_SIGMA1 : C_TAU1;
        w_init[2]  = r_long ? C_SIGMA2 : C_TAU2;
        w_init[3]  = C_SIGMA3;
        w_init[4]  = r_key0[31:0];
        w_init[5]  = r_key0[63:32];
        w_init[6]  = r_key1[31:0];
        w_init[7]  = r_key1[63:32];
        w_init[8]  = w_hi0[31:0];
        w_init[9]  = w_hi0[63:32];
        w_init[10] = w_hi1[31:0];
        w_init[11] = w_hi1[63:32];
        w_init[12] = w_ctr_eff[31:0];
        w_init[13] = w_ctr_eff[63:32];
        w_init[14] = r_nonce[31:0];
        w_init[15] = r_nonce[63:32];
    end

    // Quarter-round index select: columns then diagonals.
    always_comb begin
        w_a = {2'b00, r_qr[1:0]};
        w_c = {2'b10, r_qr[1:0] + (r_qr[2] ? 2'd2 : 2'd0)};
        w_d = {2'b11, r_qr[1:0] + (r_qr[2] ? 2'd3 : 2'd0)};
        w_b = {2'b01, r_qr[1:0] + (r_qr[2] ? 2'd1 : 2'd0)};
    end

    always_comb begin
        w_a1 = r_w[w_a] + r_w[w_b];
        w_d1 = r_w[w_d] ^ w_a1;
        w_d1 = {w_d1[15:0], w_d1[31:16]};
        w_c1 = r_w[w_c] + w_d1;
        w_b1 = r_w[w_b] ^ w_c1;
        w_b1 = {w_b1[19:0], w_b1[31:20]};
        w_a2 = w_a1 + w_b1;
        w_d2 = w_d1 ^ w_a2;
        w_d2 = {w_d2[23:0], w_d2[31:24]};
        w_c2 = w_c1 + w_d2;
        w_b2 = w_b1 ^ w_c2;
        w_b2 = {w_b2[24:0], w_b2[31:25]};
    end

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_need     = w_restart || (r_pos == 7'd0) || (r_pos > 7'd64);
    assign w_take     = (r_state == S_IDLE) && i_q_valid && !w_need && w_out_free;
    assign o_q_ready  = w_take;
    assign w_idx      = 6'(7'd64 - r_pos);
    assign w_word     = r_ks[w_idx[5:2]];
    assign w_ksb      = w_word[8 * w_idx[1:0] +: 8];
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key0 <= '0; r_key1 <= '0; r_key2 <= '0; r_key3 <= '0;
            r_long <= 1'b0; r_nonce <= '0; r_drounds <= 4'd4;
            r_state <= S_IDLE; r_ctr <= '0; r_pos <= '0; r_rst_done <= 1'b0;
            r_out_valid <= 1'b0; r_qr <= '0; r_dr_cnt <= '0; r_add_idx <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_KEY0:   r_key0 <= i_cfg_data;
                    REG_KEY1:   r_key1 <= i_cfg_data;
                    REG_KEY2:   r_key2 <= i_cfg_data;
                    REG_KEY3:   r_key3 <= i_cfg_data;
                    REG_KEYLEN: r_long <= i_cfg_data[0];
                    REG_NONCE:  r_nonce <= i_cfg_data;
                    REG_ROUNDS: r_drounds <= i_cfg_data[3:0];
                    default: ;
                endcase
            end
            if (w_take) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_key_wr) begin
                r_ctr <= '0;
                r_pos <= '0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid && w_need && w_out_free) begin
                        // Restart: build from counter zero.
                        if (w_restart) begin
                            r_ctr <= '0;
                            r_rst_done <= 1'b1;
                        end
                        for (int i = 0; i < 16; i++) r_w[i] <= w_init[i];
                        r_qr <= '0;
                        r_dr_cnt <= r_drounds;
                        r_state <= (r_drounds == 4'd0) ? S_ADD : S_ROUND;
                        r_add_idx <= '0;
                    end else if (w_take) begin
                        r_pos <= r_pos - 7'd1;
                        r_rst_done <= 1'b0;
                        r_out.data <= i_q_item.data ^ w_ksb;
                        r_out.last <= i_q_item.last;
                    end
                end
                S_ROUND: begin
                    r_w[w_a] <= w_a2;
                    r_w[w_b] <= w_b2;
                    r_w[w_c] <= w_c2;
                    r_w[w_d] <= w_d2;
                    r_qr <= r_qr + 3'd1;
                    if (r_qr == 3'd7) begin
                        r_dr_cnt <= r_dr_cnt - 4'd1;
                        if (r_dr_cnt == 4'd1) r_state <= S_ADD;
                    end
                end
                S_ADD: begin
                    // One word per cycle of feed-forward; counter still old.
                    r_ks[r_add_idx] <= r_w[r_add_idx] + w_init[r_add_idx];
                    r_add_idx <= r_add_idx + 4'd1;
                    if (r_add_idx == 4'd15) begin
                        r_ctr <= r_ctr + 64'd1;
                        r_pos <= 7'd64;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |-> (r_state == S_IDLE) && (r_pos != 7'd0))
        else $error("byte taken with empty buffer");
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= 7'd64) else $error("buffer position out of range");
    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADD && r_add_idx == 4'd15) |=> (r_pos == 7'd64))
        else $error("block end did not fill buffer");

endmodule

// ===== sv/chacha_keystream_xor_core.sv =====
// Top level: ChaCha keystream XOR with a 64-bit nonce and block counter.
// An input byte passes through the queue and the output register while bytes remain buffered.
// Each 64-byte block is built one quarter round per cycle, then one word add per cycle.
// Reset (i_rst_n synchronous, active low) clears keys, nonce and counter,
// sets double_rounds to 4 and empties the buffer and queue.
module chacha_keystream_xor_core
    import chacha_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_in
    input  logic        s_axis_tuser,   // restart
    input  logic        s_axis_tlast,   // last_in
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // data_out
    output logic        m_axis_tlast    // last_out
);

    t_item   w_in, w_q;
    logic    w_q_valid, w_q_ready;
    t_result w_out;

    assign w_in.data    = s_axis_tdata;
    assign w_in.restart = s_axis_tuser;
    assign w_in.last    = s_axis_tlast;

    chacha_front u_front (
        .i_clk, .i_rst_n,
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_item     (w_in),
        .o_q_valid  (w_q_valid),
        .i_q_ready  (w_q_ready),
        .o_q_item   (w_q)
    );

    chacha_back u_back (
        .i_clk, .i_rst_n,
        .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_q_valid   (w_q_valid),
        .o_q_ready   (w_q_ready),
        .i_q_item    (w_q),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out       (w_out)
    );

    assign m_axis_tdata = w_out.data;
    assign m_axis_tlast = w_out.last;

endmodule

// ===== bench/chacha_keystream_xor_core_tb.sv =====
// Testbench for the ChaCha keystream XOR core: streams bytes, predicts each output byte.
`timescale 1ns / 1ps

module chacha_keystream_xor_core_tb;
    import chacha_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       restart;
        logic       last;
    } t_byte_in;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_byte_out;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [63:0] i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // data_in
    logic        s_axis_tuser;   // restart
    logic        s_axis_tlast;   // last_in
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;   // data_out
    logic        m_axis_tlast;   // last_out

    chacha_keystream_xor_core dut (.*);

    // predictor copy of configuration and state
    logic [63:0] key_q [4];
    logic        long_key;
    logic [63:0] nonce_q;
    logic [3:0]  dround_cnt;
    logic [63:0] blk_ctr;
    int          bytes_left;
    logic [7:0]  ks_bytes [64];

    t_byte_in  pending_bytes [$];
    t_byte_out expected_bytes [$];
    int        fail_cnt;
    int        hold_off_cycles;
    bit        in_fire;
    bit        out_fire;

    function automatic logic [31:0] rotl(input logic [31:0] v, input int s);
        return (v << s) | (v >> (32 - s));
    endfunction

    task automatic qround(inout logic [31:0] w [16], input int a, b, c, d);
        w[a] += w[b]; w[d] = rotl(w[d] ^ w[a], 16);
        w[c] += w[d]; w[b] = rotl(w[b] ^ w[c], 12);
        w[a] += w[b]; w[d] = rotl(w[d] ^ w[a], 8);
        w[c] += w[d]; w[b] = rotl(w[b] ^ w[c], 7);
    endtask

    task automatic make_keystream_block();
        logic [31:0] init [16];
        logic [31:0] w [16];
        logic [63:0] hi0, hi1;
        hi0 = long_key ? key_q[2] : key_q[0];
        hi1 = long_key ? key_q[3] : key_q[1];
        init[0] = C_SIGMA0;
        init[1] = long_key ? C_SIGMA1 : C_TAU1;
        init[2] = long_key ? C_SIGMA2 : C_TAU2;
        init[3] = C_SIGMA3;
        init[4] = key_q[0][31:0];  init[5] = key_q[0][63:32];
        init[6] = key_q[1][31:0];  init[7] = key_q[1][63:32];
        init[8] = hi0[31:0];       init[9] = hi0[63:32];
        init[10] = hi1[31:0];      init[11] = hi1[63:32];
        init[12] = blk_ctr[31:0];  init[13] = blk_ctr[63:32];
        init[14] = nonce_q[31:0];  init[15] = nonce_q[63:32];
        w = init;
        for (int r = 0; r < dround_cnt; r++) begin
            qround(w, 0, 4, 8, 12);  qround(w, 1, 5, 9, 13);
            qround(w, 2, 6, 10, 14); qround(w, 3, 7, 11, 15);
            qround(w, 0, 5, 10, 15); qround(w, 1, 6, 11, 12);
            qround(w, 2, 7, 8, 13);  qround(w, 3, 4, 9, 14);
        end
        for (int i = 0; i < 16; i++) begin
            w[i] += init[i];
            for (int j = 0; j < 4; j++) ks_bytes[4*i+j] = w[i][8*j +: 8];
        end
        blk_ctr += 1;
    endtask

    task automatic predict_xor(input t_byte_in b);
        t_byte_out o;
        if (b.restart) begin
            blk_ctr = 0;
            bytes_left = 0;
        end
        if (bytes_left == 0) begin
            make_keystream_block();
            bytes_left = 64;
        end
        o.data = b.data ^ ks_bytes[64 - bytes_left];
        o.last = b.last;
        bytes_left--;
        expected_bytes.push_back(o);
    endtask

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // driver
    int  in_gap;
    bit  in_busy;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 0;
            s_axis_tdata  <= 0;
            s_axis_tuser  <= 0;
            s_axis_tlast  <= 0;
            in_gap = $urandom_range(0, 11);
        end else begin
            if (in_fire) begin
                in_busy = 0;
                in_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
            end else begin
                in_busy = s_axis_tvalid;
            end
            if (!in_busy) begin
                if (in_gap > 0 || pending_bytes.size() == 0) begin
                    if (in_gap > 0) in_gap--;
                    s_axis_tvalid <= 0;
                end else begin
                    t_byte_in b;
                    b = pending_bytes.pop_front();
                    s_axis_tvalid <= 1;
                    s_axis_tdata  <= b.data;
                    s_axis_tuser  <= b.restart;
                    s_axis_tlast  <= b.last;
                end
            end
        end
    end

    // predict on input acceptance
    always @(posedge i_clk) begin
        in_fire = i_rst_n && s_axis_tvalid && s_axis_tready;
        if (in_fire)
            predict_xor('{s_axis_tdata, s_axis_tuser, s_axis_tlast});
    end

    // receiver backpressure
    int out_gap;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 0;
            out_gap = 0;
        end else if (hold_off_cycles > 0) begin
            hold_off_cycles--;
            m_axis_tready <= 0;
        end else if (out_fire) begin
            out_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
            m_axis_tready <= (out_gap == 0);
        end else if (out_gap > 0) begin
            out_gap--;
            m_axis_tready <= (out_gap == 0);
        end else begin
            m_axis_tready <= 1;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        out_fire = i_rst_n && m_axis_tvalid && m_axis_tready;
        if (out_fire) begin
            if (expected_bytes.size() == 0) begin
                $error("output transaction with nothing expected: data %h", m_axis_tdata);
                fail_cnt++;
            end else begin
                t_byte_out e;
                e = expected_bytes.pop_front();
                if (m_axis_tdata !== e.data) begin
                    $error("data_out: expected %h, got %h", e.data, m_axis_tdata);
                    fail_cnt++;
                end
                if (m_axis_tlast !== e.last) begin
                    $error("last_out: expected %b, got %b", e.last, m_axis_tlast);
                    fail_cnt++;
                end
            end
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 0;
        case (idx)
            REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3: key_q[idx[1:0]] = val;
            REG_KEYLEN: long_key = val[0];
            REG_NONCE:  nonce_q = val;
            REG_ROUNDS: dround_cnt = val[3:0];
            default: ;
        endcase
        if (idx <= REG_KEYLEN) begin
            blk_ctr = 0;
            bytes_left = 0;
        end
    endtask

    task automatic wait_drained();
        while (pending_bytes.size() != 0 || s_axis_tvalid || expected_bytes.size() != 0)
            @(posedge i_clk);
        repeat (150) @(posedge i_clk);
    endtask

    task automatic queue_bytes(input int n, input int restart_odds);
        t_byte_in b;
        for (int i = 0; i < n; i++) begin
            b.data    = $urandom_range(0, 255);
            b.restart = ($urandom_range(0, restart_odds) == 0);
            b.last    = ($urandom_range(0, 15) == 0);
            pending_bytes.push_back(b);
        end
    endtask

    task automatic random_config();
        for (int i = 0; i < 4; i++)
            write_reg(i[2:0], {$urandom, $urandom});
        write_reg(REG_KEYLEN, 64'($urandom_range(0, 1)));
        write_reg(REG_NONCE, {$urandom, $urandom});
        write_reg(REG_ROUNDS, 64'($urandom_range(1, 15)));
    endtask

    initial begin
        t_byte_in b;
        i_rst_n = 0; i_cfg_we = 0; i_cfg_idx = 0; i_cfg_data = 0;
        fail_cnt = 0; hold_off_cycles = 0;
        key_q = '{default: 0}; long_key = 0; nonce_q = 0; dround_cnt = 4;
        blk_ctr = 0; bytes_left = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1;

        // directed: reset defaults, field extremes, restart, last
        b = '{8'h00, 1'b0, 1'b0}; pending_bytes.push_back(b);
        b = '{8'hff, 1'b0, 1'b1}; pending_bytes.push_back(b);
        b = '{8'h55, 1'b1, 1'b0}; pending_bytes.push_back(b);
        b = '{8'haa, 1'b0, 1'b1}; pending_bytes.push_back(b);
        b = '{8'h01, 1'b1, 1'b1}; pending_bytes.push_back(b);
        wait_drained();

        // extremes: all-ones key and nonce, max rounds, long key
        for (int i = 0; i < 4; i++) write_reg(i[2:0], '1);
        write_reg(REG_KEYLEN, 64'd1);
        write_reg(REG_NONCE, '1);
        write_reg(REG_ROUNDS, 64'd15);
        queue_bytes(20, 1000);
        wait_drained();
        // one double round, short key; nonce and round change mid-buffer
        write_reg(REG_ROUNDS, 64'd1);
        write_reg(REG_KEYLEN, 64'd0);
        queue_bytes(10, 1000);
        wait_drained();
        write_reg(REG_NONCE, 64'h0123_4567_89ab_cdef);
        write_reg(REG_ROUNDS, 64'd10);
        queue_bytes(70, 1000);
        wait_drained();
        write_reg(REG_ROUNDS, 64'd0);
        queue_bytes(66, 1000);
        wait_drained();

        // random phases; one long receiver stall in the first
        for (int p = 0; p < 8; p++) begin
            random_config();
            queue_bytes(180, 120);
            if (p == 0) hold_off_cycles = 400;
            wait_drained();
        end

        if (fail_cnt == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        #5ms;
        $display("Mismatches found");
        $finish;
    end

endmodule
